// ----- src/fcr_pkg.sv -----
package fcr_pkg;

   localparam int LEN_W = 6;
   localparam int IDX_W = 5;
   localparam int CNT_W = 8;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_INDEX_W = 3;

   localparam logic [LEN_W-1:0] LEN_GET = 6'd1;
   localparam logic [LEN_W-1:0] LEN_COLOR = 6'd4;
   localparam logic [LEN_W-1:0] LEN_PAIR = 6'd2;
   localparam logic [LEN_W-1:0] LEN_EMPTY = 6'd0;
   localparam logic [CNT_W-1:0] CNT_MAX = 8'd255;

   typedef enum logic [2:0] {
      STATUS_BAD_START = 3'd0,
      STATUS_BAD_CMD   = 3'd1,
      STATUS_BAD_LEN   = 3'd2,
      STATUS_BAD_END   = 3'd3,
      STATUS_FRAME     = 3'd4
   } rsp_status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BEGIN_CODE      = 3'd0,
      CSR_END_CODE        = 3'd1,
      CSR_SAVE_CMD_CODE   = 3'd2,
      CSR_GET_CMD_CODE    = 3'd3,
      CSR_COLOR_CMD_CODE  = 3'd4,
      CSR_PAIR_CMD_CODES  = 3'd5,
      CSR_EMPTY_CMD_CODES = 3'd6,
      CSR_SETTINGS_LENGTH = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [7:0]  begin_code;
      logic [7:0]  end_code;
      logic [7:0]  save_cmd_code;
      logic [7:0]  get_cmd_code;
      logic [7:0]  color_cmd_code;
      logic [15:0] pair_cmd_codes;
      logic [31:0] empty_cmd_codes;
      logic [4:0]  settings_length;
   } csr_type;

   typedef struct packed {
      logic             known;
      logic [LEN_W-1:0] len;
   } cmd_kind_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_BEGIN,
      OP_BAD_START,
      OP_CMD,
      OP_BAD_CMD,
      OP_LEN,
      OP_BAD_LEN,
      OP_DATA,
      OP_BAD_END,
      OP_EMPTY,
      OP_RELEASE_START,
      OP_RELEASE_STEP
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_free;
      logic is_begin;
      logic cmd_known;
      logic len_ok;
      logic len_zero;
      logic data_done;
      logic is_end;
      logic frame_empty;
      logic release_last;
   } dp_status_type;

   // Overlapping codes resolve in the order save, get, color, pair, empty.
   function automatic cmd_kind_type cmd_kind(input logic [7:0] code, input csr_type csr);
      cmd_kind_type res;
      res.known = 1'b1;
      res.len = LEN_EMPTY;
      priority if (code == csr.save_cmd_code) begin
         res.len = LEN_W'(csr.settings_length) + LEN_W'(1);
      end else if (code == csr.get_cmd_code) begin
         res.len = LEN_GET;
      end else if (code == csr.color_cmd_code) begin
         res.len = LEN_COLOR;
      end else if (code == csr.pair_cmd_codes[7:0] || code == csr.pair_cmd_codes[15:8]) begin
         res.len = LEN_PAIR;
      end else if (code == csr.empty_cmd_codes[7:0] || code == csr.empty_cmd_codes[15:8] ||
                   code == csr.empty_cmd_codes[23:16] ||
                   code == csr.empty_cmd_codes[31:24]) begin
         res.len = LEN_EMPTY;
      end else begin
         res.known = 1'b0;
      end
      return res;
   endfunction

endpackage

// ----- src/fcr_ram.sv -----
module fcr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/fcr_ctrl.sv -----
module fcr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  fcr_pkg::dp_status_type status,
   output fcr_pkg::ctrl_cmd_type  cmd
);

   import fcr_pkg::*;

   typedef enum logic [5:0] {
      S_BEGIN   = 6'b000001,
      S_CMD     = 6'b000010,
      S_LEN     = 6'b000100,
      S_DATA    = 6'b001000,
      S_END     = 6'b010000,
      S_RELEASE = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_stall = (state_ff == S_RELEASE) || !status.out_free;
   assign accept = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      cmd.op = OP_NONE;
      unique case (state_ff)
         S_BEGIN: begin
            if (accept) begin
               if (status.is_begin) begin
                  cmd.op = OP_BEGIN;
                  state_in = S_CMD;
               end else begin
                  cmd.op = OP_BAD_START;
               end
            end
         end
         S_CMD: begin
            if (accept) begin
               if (status.cmd_known) begin
                  cmd.op = OP_CMD;
                  state_in = S_LEN;
               end else begin
                  cmd.op = OP_BAD_CMD;
                  state_in = S_BEGIN;
               end
            end
         end
         S_LEN: begin
            if (accept) begin
               if (status.len_ok) begin
                  cmd.op = OP_LEN;
                  state_in = status.len_zero ? S_END : S_DATA;
               end else begin
                  cmd.op = OP_BAD_LEN;
                  state_in = S_BEGIN;
               end
            end
         end
         S_DATA: begin
            if (accept) begin
               cmd.op = OP_DATA;
               if (status.data_done) begin
                  state_in = S_END;
               end
            end
         end
         S_END: begin
            if (accept) begin
               priority if (!status.is_end) begin
                  cmd.op = OP_BAD_END;
                  state_in = S_BEGIN;
               end else if (status.frame_empty) begin
                  cmd.op = OP_EMPTY;
                  state_in = S_BEGIN;
               end else begin
                  cmd.op = OP_RELEASE_START;
                  state_in = S_RELEASE;
               end
            end
         end
         S_RELEASE: begin
            if (status.out_free) begin
               cmd.op = OP_RELEASE_STEP;
               if (status.release_last) begin
                  state_in = S_BEGIN;
               end
            end
         end
         default: begin
            state_in = S_BEGIN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_BEGIN;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- src/fcr_datapath.sv -----
module fcr_datapath #(
   parameter int MAX_PAYLOAD = 32,
   parameter int BAD_START_LIMIT = 100
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [7:0]                      req_rx_byte,
   input  fcr_pkg::ctrl_cmd_type           cmd,
   output fcr_pkg::dp_status_type          status,
   input  logic                            csr_wr_en,
   input  logic [fcr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [fcr_pkg::CSR_DATA_W-1:0]  csr_wr_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [2:0]                      rsp_status,
   output logic [7:0]                      rsp_command,
   output logic [7:0]                      rsp_payload_byte,
   output logic [4:0]                      rsp_byte_index,
   output logic                            rsp_has_payload,
   output logic                            rsp_last,
   output logic                            rsp_reboot_request
);

   import fcr_pkg::*;

   localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

   csr_type          csr_ff, csr_in;
   logic [7:0]       held_cmd_ff, held_cmd_in;
   logic [LEN_W-1:0] frame_len_ff, frame_len_in;
   logic [LEN_W-1:0] rcv_cnt_ff, rcv_cnt_in;
   logic [CNT_W-1:0] bad_cnt_ff, bad_cnt_in;
   logic [IDX_W-1:0] rel_idx_ff, rel_idx_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [2:0]       rsp_status_ff, rsp_status_in;
   logic [7:0]       rsp_command_ff, rsp_command_in;
   logic [7:0]       rsp_payload_ff, rsp_payload_in;
   logic [IDX_W-1:0] rsp_index_ff, rsp_index_in;
   logic             rsp_has_ff, rsp_has_in;
   logic             rsp_last_ff, rsp_last_in;
   logic             rsp_reboot_ff, rsp_reboot_in;

   cmd_kind_type     rx_kind, held_kind;
   logic             out_free, load, release_last;
   logic [7:0]       ram_rd_data;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign rx_kind = cmd_kind(req_rx_byte, csr_ff);
   assign held_kind = cmd_kind(held_cmd_ff, csr_ff);
   assign release_last = (LEN_W'(rel_idx_ff) + LEN_W'(1)) == frame_len_ff;

   assign status.out_free = out_free;
   assign status.is_begin = req_rx_byte == csr_ff.begin_code;
   assign status.cmd_known = rx_kind.known;
   assign status.len_ok = held_kind.known && (req_rx_byte == 8'(held_kind.len)) &&
                          (req_rx_byte <= 8'(MAX_PAYLOAD));
   assign status.len_zero = req_rx_byte == 8'd0;
   assign status.data_done = (rcv_cnt_ff + LEN_W'(1)) >= frame_len_ff;
   assign status.is_end = req_rx_byte == csr_ff.end_code;
   assign status.frame_empty = frame_len_ff == '0;
   assign status.release_last = release_last;

   always_comb begin
      csr_in = csr_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_BEGIN_CODE:      csr_in.begin_code = csr_wr_data[7:0];
            CSR_END_CODE:        csr_in.end_code = csr_wr_data[7:0];
            CSR_SAVE_CMD_CODE:   csr_in.save_cmd_code = csr_wr_data[7:0];
            CSR_GET_CMD_CODE:    csr_in.get_cmd_code = csr_wr_data[7:0];
            CSR_COLOR_CMD_CODE:  csr_in.color_cmd_code = csr_wr_data[7:0];
            CSR_PAIR_CMD_CODES:  csr_in.pair_cmd_codes = csr_wr_data[15:0];
            CSR_EMPTY_CMD_CODES: csr_in.empty_cmd_codes = csr_wr_data[31:0];
            CSR_SETTINGS_LENGTH: csr_in.settings_length = csr_wr_data[4:0];
            default:             csr_in = csr_ff;
         endcase
      end
   end

   always_comb begin
      held_cmd_in = held_cmd_ff;
      frame_len_in = frame_len_ff;
      rcv_cnt_in = rcv_cnt_ff;
      bad_cnt_in = bad_cnt_ff;
      rel_idx_in = rel_idx_ff;
      load = 1'b1;
      rsp_status_in = STATUS_FRAME;
      rsp_command_in = held_cmd_ff;
      rsp_payload_in = '0;
      rsp_index_in = '0;
      rsp_has_in = 1'b0;
      rsp_last_in = 1'b1;
      unique case (cmd.op)
         OP_BEGIN: begin
            load = 1'b0;
            bad_cnt_in = '0;
         end
         OP_BAD_START: begin
            if (bad_cnt_ff != CNT_MAX) begin
               bad_cnt_in = bad_cnt_ff + CNT_W'(1);
            end
            rsp_status_in = STATUS_BAD_START;
            rsp_command_in = '0;
         end
         OP_CMD: begin
            load = 1'b0;
            held_cmd_in = req_rx_byte;
         end
         OP_BAD_CMD: begin
            held_cmd_in = req_rx_byte;
            rsp_status_in = STATUS_BAD_CMD;
            rsp_command_in = req_rx_byte;
         end
         OP_LEN: begin
            load = 1'b0;
            frame_len_in = LEN_W'(req_rx_byte);
            rcv_cnt_in = '0;
         end
         OP_BAD_LEN: begin
            rsp_status_in = STATUS_BAD_LEN;
         end
         OP_DATA: begin
            load = 1'b0;
            rcv_cnt_in = rcv_cnt_ff + LEN_W'(1);
         end
         OP_BAD_END: begin
            rsp_status_in = STATUS_BAD_END;
         end
         OP_EMPTY: begin
            held_cmd_in = '0;
         end
         OP_RELEASE_START: begin
            load = 1'b0;
         end
         OP_RELEASE_STEP: begin
            rsp_payload_in = ram_rd_data;
            rsp_index_in = rel_idx_ff;
            rsp_has_in = 1'b1;
            rsp_last_in = release_last;
            if (release_last) begin
               rel_idx_in = '0;
               held_cmd_in = '0;
            end else begin
               rel_idx_in = rel_idx_ff + IDX_W'(1);
            end
         end
         default: begin
            load = 1'b0;
         end
      endcase
      rsp_reboot_in = bad_cnt_in > CNT_W'(BAD_START_LIMIT);
      rsp_valid_in = load || (rsp_valid_ff && !out_free);
   end

   fcr_ram #(
      .WIDTH(8),
      .DEPTH(MAX_PAYLOAD)
   ) u_payload_ram (
      .clock  (clock),
      .wr_en  (cmd.op == OP_DATA),
      .wr_addr(ADDR_W'(rcv_cnt_ff)),
      .wr_data(req_rx_byte),
      .rd_addr(ADDR_W'(rel_idx_in)),
      .rd_data(ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.begin_code <= 8'd170;
         csr_ff.end_code <= 8'd85;
         csr_ff.save_cmd_code <= 8'd16;
         csr_ff.get_cmd_code <= 8'd17;
         csr_ff.color_cmd_code <= 8'd18;
         csr_ff.pair_cmd_codes <= 16'h1413;
         csr_ff.empty_cmd_codes <= 32'h1817_1615;
         csr_ff.settings_length <= 5'd16;
         held_cmd_ff <= '0;
         frame_len_ff <= '0;
         rcv_cnt_ff <= '0;
         bad_cnt_ff <= '0;
         rel_idx_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         csr_ff <= csr_in;
         held_cmd_ff <= held_cmd_in;
         frame_len_ff <= frame_len_in;
         rcv_cnt_ff <= rcv_cnt_in;
         bad_cnt_ff <= bad_cnt_in;
         rel_idx_ff <= rel_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_command_ff <= rsp_command_in;
         rsp_payload_ff <= rsp_payload_in;
         rsp_index_ff <= rsp_index_in;
         rsp_has_ff <= rsp_has_in;
         rsp_last_ff <= rsp_last_in;
         rsp_reboot_ff <= rsp_reboot_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_command = rsp_command_ff;
   assign rsp_payload_byte = rsp_payload_ff;
   assign rsp_byte_index = rsp_index_ff;
   assign rsp_has_payload = rsp_has_ff;
   assign rsp_last = rsp_last_ff;
   assign rsp_reboot_request = rsp_reboot_ff;

endmodule

// ----- src/framed_command_receiver.sv -----
// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_stall  req_rx_byte
// rsp       out        rsp_valid / rsp_stall  status, command, payload byte, index, flags
// csr       in         csr_wr_en              csr_index, csr_wr_data
//
// A header, data or error byte is accepted while req_stall is low; an error gives one result the next cycle.
// A valid end byte releases the buffered payload from the payload RAM at one result per
// cycle while rsp is not stalled.
// Reset is synchronous and restores the default codes; the payload RAM is not cleared.
// A stall on rsp holds the result register and stalls req until it drains.
module framed_command_receiver #(
   parameter int MAX_PAYLOAD = 32,
   parameter int BAD_START_LIMIT = 100
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [7:0]                      req_rx_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [2:0]                      rsp_status,
   output logic [7:0]                      rsp_command,
   output logic [7:0]                      rsp_payload_byte,
   output logic [4:0]                      rsp_byte_index,
   output logic                            rsp_has_payload,
   output logic                            rsp_last,
   output logic                            rsp_reboot_request,
   input  logic                            csr_wr_en,
   input  logic [fcr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [fcr_pkg::CSR_DATA_W-1:0]  csr_wr_data
);

   import fcr_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   fcr_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .status   (status),
      .cmd      (cmd)
   );

   fcr_datapath #(
      .MAX_PAYLOAD    (MAX_PAYLOAD),
      .BAD_START_LIMIT(BAD_START_LIMIT)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_rx_byte       (req_rx_byte),
      .cmd               (cmd),
      .status            (status),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wr_data       (csr_wr_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_command       (rsp_command),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_byte_index    (rsp_byte_index),
      .rsp_has_payload   (rsp_has_payload),
      .rsp_last          (rsp_last),
      .rsp_reboot_request(rsp_reboot_request)
   );

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("Input accepted while a result is held.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_FRAME |-> rsp_last && !rsp_has_payload)
      else $error("Error result is not a single last transaction.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_payload |-> rsp_payload_byte == 8'd0 && rsp_byte_index == 5'd0)
      else $error("Result without payload carries payload fields.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_BAD_START |-> rsp_command == 8'd0)
      else $error("Bad start result carries a command.");

endmodule

// ----- tb/sv/fcr_checker.sv -----
module fcr_checker #(
   parameter int MAX_PAYLOAD = 32,
   parameter int BAD_START_LIMIT = 100
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic [7:0]                      req_rx_byte,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic [2:0]                      rsp_status,
   input  logic [7:0]                      rsp_command,
   input  logic [7:0]                      rsp_payload_byte,
   input  logic [4:0]                      rsp_byte_index,
   input  logic                            rsp_has_payload,
   input  logic                            rsp_last,
   input  logic                            rsp_reboot_request,
   input  logic                            csr_wr_en,
   input  logic [fcr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [fcr_pkg::CSR_DATA_W-1:0]  csr_wr_data,
   output int                              mismatch_count,
   output int                              results_owed
);
   timeunit 1ns;
   timeprecision 1ps;

   import fcr_pkg::*;

   typedef enum logic [2:0] {
      SEEK_BEGIN,
      SEEK_COMMAND,
      SEEK_LENGTH,
      TAKE_PAYLOAD,
      SEEK_END
   } parse_phase_type;

   typedef struct packed {
      rsp_status_type status;
      logic [7:0]     command;
      logic [7:0]     payload_byte;
      logic [4:0]     byte_index;
      logic           has_payload;
      logic           last;
      logic           reboot_request;
   } frame_result_type;

   csr_type          codes;
   parse_phase_type  parse_phase;
   logic [7:0]       held_command;
   int               frame_length;
   int               bytes_taken;
   logic [7:0]       payload_ram [MAX_PAYLOAD];
   logic [7:0]       bad_starts;
   frame_result_type awaited_results [$];

   // A code that sits in several registers takes the class of the first match.
   function automatic int command_length(input logic [7:0] code);
      if (code == codes.save_cmd_code) return int'(codes.settings_length) + 1;
      if (code == codes.get_cmd_code) return 1;
      if (code == codes.color_cmd_code) return 4;
      if (code == codes.pair_cmd_codes[7:0] || code == codes.pair_cmd_codes[15:8]) return 2;
      if (code == codes.empty_cmd_codes[7:0] || code == codes.empty_cmd_codes[15:8] ||
          code == codes.empty_cmd_codes[23:16] || code == codes.empty_cmd_codes[31:24]) begin
         return 0;
      end
      return -1;
   endfunction

   task automatic owe_result(input rsp_status_type status, input logic [7:0] command,
                             input logic [7:0] payload_byte, input int byte_index,
                             input logic has_payload, input logic last);
      frame_result_type r;
      r.status         = status;
      r.command        = command;
      r.payload_byte   = payload_byte;
      r.byte_index     = 5'(byte_index);
      r.has_payload    = has_payload;
      r.last           = last;
      r.reboot_request = (bad_starts > BAD_START_LIMIT);
      awaited_results.push_back(r);
   endtask

   task automatic parse_rx_byte(input logic [7:0] rx);
      int expected_len;
      case (parse_phase)
         SEEK_BEGIN: begin
            if (rx == codes.begin_code) begin
               bad_starts  = '0;
               parse_phase = SEEK_COMMAND;
            end else begin
               if (bad_starts != CNT_MAX) bad_starts++;
               owe_result(STATUS_BAD_START, 8'h00, 8'h00, 0, 1'b0, 1'b1);
            end
         end
         SEEK_COMMAND: begin
            held_command = rx;
            if (command_length(rx) >= 0) begin
               parse_phase = SEEK_LENGTH;
            end else begin
               parse_phase = SEEK_BEGIN;
               owe_result(STATUS_BAD_CMD, held_command, 8'h00, 0, 1'b0, 1'b1);
            end
         end
         SEEK_LENGTH: begin
            expected_len = command_length(held_command);
            if (expected_len < 0 || expected_len != int'(rx) || int'(rx) > MAX_PAYLOAD) begin
               parse_phase = SEEK_BEGIN;
               owe_result(STATUS_BAD_LEN, held_command, 8'h00, 0, 1'b0, 1'b1);
            end else begin
               frame_length = int'(rx);
               bytes_taken  = 0;
               parse_phase  = (frame_length > 0) ? TAKE_PAYLOAD : SEEK_END;
            end
         end
         TAKE_PAYLOAD: begin
            if (bytes_taken < MAX_PAYLOAD) payload_ram[bytes_taken] = rx;
            bytes_taken++;
            if (bytes_taken >= frame_length) parse_phase = SEEK_END;
         end
         SEEK_END: begin
            parse_phase = SEEK_BEGIN;
            if (rx != codes.end_code) begin
               owe_result(STATUS_BAD_END, held_command, 8'h00, 0, 1'b0, 1'b1);
            end else if (frame_length == 0) begin
               owe_result(STATUS_FRAME, held_command, 8'h00, 0, 1'b0, 1'b1);
               held_command = '0;
            end else begin
               for (int i = 0; i < frame_length && i < MAX_PAYLOAD; i++) begin
                  owe_result(STATUS_FRAME, held_command, payload_ram[i], i, 1'b1,
                             i + 1 == frame_length);
               end
               held_command = '0;
            end
         end
         default: begin
            parse_phase = SEEK_BEGIN;
         end
      endcase
   endtask

   task automatic check_field(input string field, input logic [7:0] want,
                              input logic [7:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      frame_result_type want;
      if (reset) begin
         codes.begin_code      = 8'd170;
         codes.end_code        = 8'd85;
         codes.save_cmd_code   = 8'd16;
         codes.get_cmd_code    = 8'd17;
         codes.color_cmd_code  = 8'd18;
         codes.pair_cmd_codes  = 16'd5139;
         codes.empty_cmd_codes = 32'd404166165;
         codes.settings_length = 5'd16;
         parse_phase    = SEEK_BEGIN;
         held_command   = '0;
         frame_length   = 0;
         bytes_taken    = 0;
         bad_starts     = '0;
         mismatch_count = 0;
         awaited_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_results.size() == 0) begin
               $display("%0t: unexpected result, expected none, got status %0d command 0x%02h %s",
                        $time, rsp_status, rsp_command,
                        $sformatf("payload 0x%02h index %0d", rsp_payload_byte, rsp_byte_index));
               mismatch_count++;
            end else begin
               want = awaited_results.pop_front();
               check_field("status", want.status, rsp_status);
               check_field("command", want.command, rsp_command);
               check_field("payload_byte", want.payload_byte, rsp_payload_byte);
               check_field("byte_index", want.byte_index, rsp_byte_index);
               check_field("has_payload", want.has_payload, rsp_has_payload);
               check_field("last", want.last, rsp_last);
               check_field("reboot_request", want.reboot_request, rsp_reboot_request);
            end
         end
         if (req_valid && !req_stall) parse_rx_byte(req_rx_byte);
         if (csr_wr_en) begin
            case (csr_index_type'(csr_index))
               CSR_BEGIN_CODE:      codes.begin_code      = csr_wr_data[7:0];
               CSR_END_CODE:        codes.end_code        = csr_wr_data[7:0];
               CSR_SAVE_CMD_CODE:   codes.save_cmd_code   = csr_wr_data[7:0];
               CSR_GET_CMD_CODE:    codes.get_cmd_code    = csr_wr_data[7:0];
               CSR_COLOR_CMD_CODE:  codes.color_cmd_code  = csr_wr_data[7:0];
               CSR_PAIR_CMD_CODES:  codes.pair_cmd_codes  = csr_wr_data[15:0];
               CSR_EMPTY_CMD_CODES: codes.empty_cmd_codes = csr_wr_data[31:0];
               CSR_SETTINGS_LENGTH: codes.settings_length = csr_wr_data[4:0];
               default: ;
            endcase
         end
      end
      results_owed = awaited_results.size();
   end

endmodule

// ----- tb/sv/tb.sv -----
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import fcr_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 40;
   localparam int PHASE_BYTES = 28;
   localparam int STRAY_RUN = 110;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [7:0]             req_rx_byte = 8'h00;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [2:0]             rsp_status;
   logic [7:0]             rsp_command;
   logic [7:0]             rsp_payload_byte;
   logic [4:0]             rsp_byte_index;
   logic                   rsp_has_payload;
   logic                   rsp_last;
   logic                   rsp_reboot_request;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wr_data = '0;

   int      mismatch_count;
   int      results_owed;
   int      idle_pct = 0;
   int      stall_pct = 0;
   int      bytes_sent = 0;
   int      results_seen = 0;
   int      quiet_cycles = 0;
   csr_type cfg;

   framed_command_receiver u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_command        (rsp_command),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_byte_index     (rsp_byte_index),
      .rsp_has_payload    (rsp_has_payload),
      .rsp_last           (rsp_last),
      .rsp_reboot_request (rsp_reboot_request),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wr_data        (csr_wr_data)
   );

   fcr_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_command        (rsp_command),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_byte_index     (rsp_byte_index),
      .rsp_has_payload    (rsp_has_payload),
      .rsp_last           (rsp_last),
      .rsp_reboot_request (rsp_reboot_request),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wr_data        (csr_wr_data),
      .mismatch_count     (mismatch_count),
      .results_owed       (results_owed)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (!reset && rsp_valid && !rsp_stall) results_seen <= results_seen + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("[framed_command_receiver] ERROR");
         $finish;
      end
   end

   task automatic send_byte(input logic [7:0] value);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= value;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
   endtask

   // Upper data bits beyond the register width carry junk that must be ignored.
   task automatic write_reg(input csr_index_type index, input logic [31:0] value,
                            input int width);
      csr_wr_en   <= 1'b1;
      csr_index   <= index;
      csr_wr_data <= ($urandom << width) | value;
      @(posedge clock);
   endtask

   task automatic program_codes(input csr_type c);
      cfg = c;
      write_reg(CSR_BEGIN_CODE, 32'(c.begin_code), 8);
      write_reg(CSR_END_CODE, 32'(c.end_code), 8);
      write_reg(CSR_SAVE_CMD_CODE, 32'(c.save_cmd_code), 8);
      write_reg(CSR_GET_CMD_CODE, 32'(c.get_cmd_code), 8);
      write_reg(CSR_COLOR_CMD_CODE, 32'(c.color_cmd_code), 8);
      write_reg(CSR_PAIR_CMD_CODES, 32'(c.pair_cmd_codes), 16);
      write_reg(CSR_EMPTY_CMD_CODES, c.empty_cmd_codes, 32);
      write_reg(CSR_SETTINGS_LENGTH, 32'(c.settings_length), 5);
      csr_wr_en <= 1'b0;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (results_owed != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [7:0] stray_byte();
      logic [7:0] b;
      b = 8'($urandom);
      if (b == cfg.begin_code) b = b ^ 8'h01;
      return b;
   endfunction

   task automatic pick_command(output logic [7:0] code, output int length);
      case ($urandom_range(4))
         0: begin
            code   = cfg.save_cmd_code;
            length = int'(cfg.settings_length) + 1;
         end
         1: begin
            code   = cfg.get_cmd_code;
            length = 1;
         end
         2: begin
            code   = cfg.color_cmd_code;
            length = 4;
         end
         3: begin
            code   = $urandom_range(1) ? cfg.pair_cmd_codes[15:8] : cfg.pair_cmd_codes[7:0];
            length = 2;
         end
         default: begin
            code   = cfg.empty_cmd_codes[8*$urandom_range(3) +: 8];
            length = 0;
         end
      endcase
   endtask

   // Mostly well-formed frames with random payload, the rest noise and broken frames.
   task automatic send_frame();
      int         pick;
      int         length;
      logic [7:0] code;
      pick = $urandom_range(99);
      pick_command(code, length);
      if (pick < 12) begin
         repeat ($urandom_range(1, 3)) send_byte(stray_byte());
      end else if (pick < 20) begin
         send_byte(cfg.begin_code);
         send_byte(8'($urandom));
         send_byte(8'($urandom));
      end else if (pick < 28) begin
         send_byte(cfg.begin_code);
         send_byte(code);
         send_byte(8'(length + $urandom_range(1, 40)));
      end else begin
         send_byte(cfg.begin_code);
         send_byte(code);
         send_byte(8'(length));
         repeat (length) send_byte(8'($urandom));
         send_byte(pick < 36 ? 8'($urandom) : cfg.end_code);
      end
   endtask

   task automatic send_random_frames(input int count);
      int first;
      first = bytes_sent;
      while (bytes_sent - first < count) send_frame();
   endtask

   initial begin
      csr_type wide_codes;
      csr_type narrow_codes;
      csr_type shuffled_codes;

      cfg.begin_code      = 8'd170;
      cfg.end_code        = 8'd85;
      cfg.save_cmd_code   = 8'd16;
      cfg.get_cmd_code    = 8'd17;
      cfg.color_cmd_code  = 8'd18;
      cfg.pair_cmd_codes  = 16'd5139;
      cfg.empty_cmd_codes = 32'd404166165;
      cfg.settings_length = 5'd16;

      // Heavy code overlap, longest save frame.
      wide_codes.begin_code      = 8'h00;
      wide_codes.end_code        = 8'hFF;
      wide_codes.save_cmd_code   = 8'h00;
      wide_codes.get_cmd_code    = 8'hFF;
      wide_codes.color_cmd_code  = 8'h80;
      wide_codes.pair_cmd_codes  = 16'h0180;
      wide_codes.empty_cmd_codes = 32'h7FFF_FFFF;
      wide_codes.settings_length = 5'd31;

      narrow_codes.begin_code      = 8'hFF;
      narrow_codes.end_code        = 8'h00;
      narrow_codes.save_cmd_code   = 8'h5A;
      narrow_codes.get_cmd_code    = 8'hA5;
      narrow_codes.color_cmd_code  = 8'h3C;
      narrow_codes.pair_cmd_codes  = 16'hFFFF;
      narrow_codes.empty_cmd_codes = 32'h0000_0000;
      narrow_codes.settings_length = 5'd1;

      shuffled_codes.begin_code      = 8'($urandom);
      shuffled_codes.end_code        = 8'($urandom);
      shuffled_codes.save_cmd_code   = 8'($urandom);
      shuffled_codes.get_cmd_code    = 8'($urandom);
      shuffled_codes.color_cmd_code  = 8'($urandom);
      shuffled_codes.pair_cmd_codes  = 16'($urandom);
      shuffled_codes.empty_cmd_codes = $urandom | 32'h8000_0000;
      shuffled_codes.settings_length = 5'($urandom_range(1, 31));

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      idle_pct  = 7;
      stall_pct = 77;
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(cfg.begin_code);
      send_byte(cfg.empty_cmd_codes[7:0]);
      send_byte(8'd0);
      send_byte(cfg.end_code);
      send_byte(cfg.begin_code);
      send_byte(cfg.get_cmd_code);
      send_byte(8'd1);
      send_byte(8'hFF);
      send_byte(cfg.end_code);
      send_byte(cfg.begin_code);
      send_byte(8'hFF);
      send_byte(cfg.begin_code);
      send_byte(cfg.color_cmd_code);
      send_byte(8'hFF);
      send_byte(cfg.begin_code);
      send_byte(cfg.pair_cmd_codes[15:8]);
      send_byte(8'd2);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h00);
      send_random_frames(PHASE_BYTES);
      drain();

      idle_pct  = 77;
      stall_pct = 7;
      program_codes(wide_codes);
      send_random_frames(PHASE_BYTES);
      drain();

      // A long run outside any frame drives the bad start count past the reboot limit.
      idle_pct  = 0;
      stall_pct = 0;
      program_codes(narrow_codes);
      repeat (STRAY_RUN) send_byte(stray_byte());
      send_random_frames(PHASE_BYTES);
      drain();

      program_codes(shuffled_codes);
      send_random_frames(PHASE_BYTES);
      drain();

      @(negedge clock);
      $display("Sent %0d bytes under default, overlapping, minimal and random command codes;",
               bytes_sent);
      $display("checked %0d results including a raised reboot request.", results_seen);
      if (mismatch_count == 0 && results_owed == 0) begin
         $display("[framed_command_receiver] OK");
      end else begin
         $display("[framed_command_receiver] ERROR");
      end
      $finish;
   end

endmodule

// ----- files.f -----
src/fcr_pkg.sv
src/fcr_ram.sv
src/fcr_ctrl.sv
src/fcr_datapath.sv
src/framed_command_receiver.sv
tb/sv/fcr_checker.sv
tb/sv/tb.sv
